[rtl/hti_pkg.sv]
// Shared constants and control types for the hex8 trilinear interpolator.
package hti_pkg;

  // Field formats
  localparam int unsigned COORD_WIDTH     = 16;     // Q2.14 natural coordinate
  localparam int unsigned COORD_ONE       = 16384;  // 1.0 in Q2.14
  localparam int unsigned FACTOR_WIDTH    = COORD_WIDTH + 1;  // 1 +- c, exact
  localparam int unsigned WEIGHT_WIDTH    = 48;     // triple factor product, exact
  localparam int unsigned WEIGHT_SPLIT    = 24;     // low half of weight for partials
  localparam int unsigned FRAC_SHIFT      = 45;     // Q3.45 weight -> Q15.16 result
  localparam int unsigned NUM_CORNERS     = 8;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Corner sign patterns, bit k set means the (1 + c) factor for corner k
  localparam logic [NUM_CORNERS-1:0] SIGN_X = 8'b0110_0110;
  localparam logic [NUM_CORNERS-1:0] SIGN_Y = 8'b1100_1100;
  localparam logic [NUM_CORNERS-1:0] SIGN_Z = 8'b1111_0000;

  // Pipeline depth
  localparam int unsigned LANE_STAGES  = 5;
  localparam int unsigned MERGE_STAGES = 4;
  localparam int unsigned PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  // Per-stage load enables into a corner lane
  typedef struct packed {
    logic prod_xy;
    logic weight;
    logic part;
    logic split;
    logic sum;
  } lane_ctl_t;

  // Per-stage load enables into the merge tree
  typedef struct packed {
    logic pair;
    logic quad;
    logic total;
    logic result;
  } merge_ctl_t;

endpackage

[rtl/hti_if.sv]
// Valid/ready channel interfaces for the interpolator input and result.
interface hti_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [15:0]            coord_x;
  logic signed [15:0]            coord_y;
  logic signed [15:0]            coord_z;
  logic signed [VALUE_WIDTH-1:0] corner_value_0;
  logic signed [VALUE_WIDTH-1:0] corner_value_1;
  logic signed [VALUE_WIDTH-1:0] corner_value_2;
  logic signed [VALUE_WIDTH-1:0] corner_value_3;
  logic signed [VALUE_WIDTH-1:0] corner_value_4;
  logic signed [VALUE_WIDTH-1:0] corner_value_5;
  logic signed [VALUE_WIDTH-1:0] corner_value_6;
  logic signed [VALUE_WIDTH-1:0] corner_value_7;

  modport source (
    output valid, coord_x, coord_y, coord_z,
    output corner_value_0, corner_value_1, corner_value_2, corner_value_3,
    output corner_value_4, corner_value_5, corner_value_6, corner_value_7,
    input  ready
  );

  modport sink (
    input  valid, coord_x, coord_y, coord_z,
    input  corner_value_0, corner_value_1, corner_value_2, corner_value_3,
    input  corner_value_4, corner_value_5, corner_value_6, corner_value_7,
    output ready
  );
endinterface

interface hti_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] interp_value;
  logic                          saturated;

  modport source (
    output valid, interp_value, saturated,
    input  ready
  );

  modport sink (
    input  valid, interp_value, saturated,
    output ready
  );
endinterface

[rtl/hti_lane.sv]
// One corner lane: shape-function weight and weight times corner value.
module hti_lane
  import hti_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned CORNER      = 0
) (
  input  logic                                       clk_i,
  input  lane_ctl_t                                  ctl_i,
  input  logic signed [COORD_WIDTH-1:0]              coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]              coord_y_i,
  input  logic signed [COORD_WIDTH-1:0]              coord_z_i,
  input  logic signed [VALUE_WIDTH-1:0]              value_i,
  output logic signed [WEIGHT_WIDTH+VALUE_WIDTH-1:0] prod_o
);

  localparam int unsigned PW  = WEIGHT_WIDTH + VALUE_WIDTH;   // exact product width
  localparam int unsigned VLW = (VALUE_WIDTH + 1) / 2;        // low value chunk
  localparam int unsigned VHW = VALUE_WIDTH - VLW;            // high value chunk
  localparam int unsigned WLW = WEIGHT_SPLIT;                 // low weight chunk
  localparam int unsigned WHW = WEIGHT_WIDTH - WEIGHT_SPLIT;  // high weight chunk
  localparam int unsigned XYW = 2 * FACTOR_WIDTH;

  localparam logic signed [FACTOR_WIDTH-1:0] ONE_F = FACTOR_WIDTH'(COORD_ONE);

  // Factors (1 +- c) for this corner, exact in 17 bits
  logic signed [FACTOR_WIDTH-1:0] fx, fy, fz;
  logic signed [FACTOR_WIDTH-1:0] cx_e, cy_e, cz_e;

  assign cx_e = FACTOR_WIDTH'(coord_x_i);
  assign cy_e = FACTOR_WIDTH'(coord_y_i);
  assign cz_e = FACTOR_WIDTH'(coord_z_i);
  assign fx   = SIGN_X[CORNER] ? (ONE_F + cx_e) : (ONE_F - cx_e);
  assign fy   = SIGN_Y[CORNER] ? (ONE_F + cy_e) : (ONE_F - cy_e);
  assign fz   = SIGN_Z[CORNER] ? (ONE_F + cz_e) : (ONE_F - cz_e);

  // Stage 1: x*y factor product
  logic signed [XYW-1:0]          pxy_d, pxy_q;
  logic signed [FACTOR_WIDTH-1:0] fz_q;
  logic signed [VALUE_WIDTH-1:0]  v1_q;

  assign pxy_d = fx * fy;

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_xy) begin
      pxy_q <= pxy_d;
      fz_q  <= fz;
      v1_q  <= value_i;
    end
  end

  // Stage 2: full weight, magnitude below 2^47
  logic signed [XYW+FACTOR_WIDTH-1:0] w_full;
  logic signed [WEIGHT_WIDTH-1:0]     w_q;
  logic signed [VALUE_WIDTH-1:0]      v2_q;

  assign w_full = pxy_q * fz_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.weight) begin
      w_q  <= $signed(w_full[WEIGHT_WIDTH-1:0]);
      v2_q <= v1_q;
    end
  end

  // Stage 3: four partial products, low chunks taken as unsigned
  logic signed [WLW:0]       w_lo;
  logic signed [WHW-1:0]     w_hi;
  logic signed [VLW:0]       v_lo;
  logic signed [VHW-1:0]     v_hi;
  logic signed [WLW+VLW+1:0] ll_d, ll_q;
  logic signed [WLW+VHW:0]   lh_d, lh_q;
  logic signed [WHW+VLW:0]   hl_d, hl_q;
  logic signed [WHW+VHW-1:0] hh_d, hh_q;

  assign w_lo = $signed({1'b0, w_q[WLW-1:0]});
  assign w_hi = $signed(w_q[WEIGHT_WIDTH-1:WLW]);
  assign v_lo = $signed({1'b0, v2_q[VLW-1:0]});
  assign v_hi = $signed(v2_q[VALUE_WIDTH-1:VLW]);
  assign ll_d = w_lo * v_lo;
  assign lh_d = w_lo * v_hi;
  assign hl_d = w_hi * v_lo;
  assign hh_d = w_hi * v_hi;

  always_ff @(posedge clk_i) begin
    if (ctl_i.part) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  // Stage 4: high*high and low*low abut without overlap; cross terms add
  logic signed [PW-1:0] base_d, base_q;
  logic signed [PW-1:0] cross_d, cross_q;

  assign base_d  = $signed({hh_q, ll_q[WLW+VLW-1:0]});
  assign cross_d = (PW'(lh_q) <<< VLW) + (PW'(hl_q) <<< WLW);

  always_ff @(posedge clk_i) begin
    if (ctl_i.split) begin
      base_q  <= base_d;
      cross_q <= cross_d;
    end
  end

  // Stage 5: exact weighted corner value
  logic signed [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum) begin
      prod_q <= base_q + cross_q;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/hti_merge.sv]
// Merge tree: sums the eight lane products, rounds and saturates.
module hti_merge
  import hti_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  merge_ctl_t                                 ctl_i,
  input  logic signed [WEIGHT_WIDTH+VALUE_WIDTH-1:0] prod_i [NUM_CORNERS],
  output logic signed [VALUE_WIDTH-1:0]              interp_value_o,
  output logic                                       saturated_o
);

  localparam int unsigned PW  = WEIGHT_WIDTH + VALUE_WIDTH;
  localparam int unsigned RW  = PW + 4;               // sum plus rounding carry
  localparam int unsigned SHW = RW - FRAC_SHIFT;      // rounded result width

  localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Level 1: pairs
  logic signed [PW:0] pair_q [4];

  always_ff @(posedge clk_i) begin
    if (ctl_i.pair) begin
      for (int i = 0; i < 4; i++) begin
        pair_q[i] <= (PW+1)'(prod_i[2*i]) + (PW+1)'(prod_i[2*i+1]);
      end
    end
  end

  // Level 2: quads
  logic signed [PW+1:0] quad_q [2];

  always_ff @(posedge clk_i) begin
    if (ctl_i.quad) begin
      for (int i = 0; i < 2; i++) begin
        quad_q[i] <= (PW+2)'(pair_q[2*i]) + (PW+2)'(pair_q[2*i+1]);
      end
    end
  end

  // Level 3: exact total
  logic signed [PW+2:0] total_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.total) begin
      total_q <= (PW+3)'(quad_q[0]) + (PW+3)'(quad_q[1]);
    end
  end

  // Round half up, drop fraction, clip to the value range
  logic signed [RW-1:0]          rnd;
  logic        [SHW-1:0]         shr;
  logic        [SHW-VALUE_WIDTH:0] top;
  logic                          fits;
  logic signed [VALUE_WIDTH-1:0] res_d;
  logic                          sat_d;

  assign rnd  = (RW)'(total_q) + $signed(HALF);
  assign shr  = rnd[RW-1:FRAC_SHIFT];
  assign top  = shr[SHW-1:VALUE_WIDTH-1];
  assign fits = (&top) | ~(|top);

  always_comb begin
    sat_d = ~fits;
    if (fits) begin
      res_d = $signed(shr[VALUE_WIDTH-1:0]);
    end else if (shr[SHW-1]) begin
      res_d = VMIN;
    end else begin
      res_d = VMAX;
    end
  end

  // Result register, doubles as the output stage
  logic signed [VALUE_WIDTH-1:0] res_q;
  logic                          sat_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.result) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign interp_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

[rtl/hex8_trilinear_interpolation.sv]
// Top level of the hex8 trilinear shape-function interpolator.
// Each transaction carries the Q2.14 natural coordinates of one point and the
// eight Q15.16 corner values of one nodal quantity; the block returns the
// weighted sum of the trilinear shape functions, rounded half up once from
// the exact sum and saturated, with a flag when clipping took place. The
// datapath is a 9-stage pipeline: eight corner lanes (5 stages each: two
// factor products, four partial products of the weight-value multiply, and
// two adds) feed a registered adder tree and a round/saturate result
// register. One transaction is accepted per cycle unless the pipeline is
// full and the output stalls; a stall on the output fills empty stages first,
// so input keeps flowing until the pipeline is full.
module hex8_trilinear_interpolation
  import hti_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hti_in_if.sink        in_i,
  hti_out_if.source     out_o
);

  localparam int unsigned PW = WEIGHT_WIDTH + VALUE_WIDTH;

  // Stage valids and load enables; a stage loads when empty or when it drains
  logic [PIPE_STAGES-1:0] valid_q, valid_d;
  logic [PIPE_STAGES-1:0] en;

  always_comb begin
    en[PIPE_STAGES-1] = ~valid_q[PIPE_STAGES-1] | out_o.ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = ~valid_q[i] | en[i+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < PIPE_STAGES; i++) begin
      if (en[i]) begin
        valid_d[i] = (i == 0) ? in_i.valid : valid_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = valid_q[PIPE_STAGES-1];

  // Stage enables into the lanes and the merge tree
  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;

  assign lane_ctl.prod_xy  = en[0];
  assign lane_ctl.weight   = en[1];
  assign lane_ctl.part     = en[2];
  assign lane_ctl.split    = en[3];
  assign lane_ctl.sum      = en[4];
  assign merge_ctl.pair    = en[LANE_STAGES];
  assign merge_ctl.quad    = en[LANE_STAGES+1];
  assign merge_ctl.total   = en[LANE_STAGES+2];
  assign merge_ctl.result  = en[LANE_STAGES+3];

  // Corner values gathered for the lanes
  logic signed [VALUE_WIDTH-1:0] corner [NUM_CORNERS];

  assign corner[0] = in_i.corner_value_0;
  assign corner[1] = in_i.corner_value_1;
  assign corner[2] = in_i.corner_value_2;
  assign corner[3] = in_i.corner_value_3;
  assign corner[4] = in_i.corner_value_4;
  assign corner[5] = in_i.corner_value_5;
  assign corner[6] = in_i.corner_value_6;
  assign corner[7] = in_i.corner_value_7;

  // One lane per corner
  logic signed [PW-1:0] prod [NUM_CORNERS];

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
    hti_lane #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CORNER      (k)
    ) u_lane (
      .clk_i     (clk_i),
      .ctl_i     (lane_ctl),
      .coord_x_i (in_i.coord_x),
      .coord_y_i (in_i.coord_y),
      .coord_z_i (in_i.coord_z),
      .value_i   (corner[k]),
      .prod_o    (prod[k])
    );
  end

  // Sum, round and saturate
  hti_merge #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .clk_i          (clk_i),
    .ctl_i          (merge_ctl),
    .prod_i         (prod),
    .interp_value_o (out_o.interp_value),
    .saturated_o    (out_o.saturated)
  );

endmodule

[dv/hex8_trilinear_interpolation_checker.sv]
// Scoreboard for the hex8 interpolator: predicts each result and compares it.
module hex8_trilinear_interpolation_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hti_in_if           in_mon_i,
  hti_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned clipped_o
);

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned FRAC_BITS   = 45;

  // Corners whose factor is (1 + c), in the corner order of the element
  localparam logic [7:0] X_PLUS = 8'b0110_0110;
  localparam logic [7:0] Y_PLUS = 8'b1100_1100;
  localparam logic [7:0] Z_PLUS = 8'b1111_0000;

  localparam logic signed [17:0]  FACTOR_ONE = 18'sd16384;
  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [127:0] VAL_MAX    = (128'sd1 <<< (VALUE_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] VAL_MIN    = -(128'sd1 <<< (VALUE_WIDTH - 1));

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          saturated;
  } interp_result_t;

  interp_result_t                expected_results[$];
  interp_result_t                oldest;
  logic signed [VALUE_WIDTH-1:0] corner_buf [8];
  int unsigned                   mismatch_count = 0;
  int unsigned                   pending_count  = 0;
  int unsigned                   result_count   = 0;
  int unsigned                   clip_count     = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;
  assign checked_o    = result_count;
  assign clipped_o    = clip_count;

  // Exact weighted sum of the eight corner values, rounded half up and clipped
  function automatic interp_result_t trilinear_sum(
    input logic signed [15:0]             cx,
    input logic signed [15:0]             cy,
    input logic signed [15:0]             cz,
    input logic signed [VALUE_WIDTH-1:0]  corner [8]
  );
    logic signed [17:0]  fx, fy, fz;
    logic signed [47:0]  weight;
    logic signed [127:0] term, acc, rounded;
    interp_result_t      r;
    int                  k;
    acc = '0;
    for (k = 0; k < 8; k++) begin
      fx     = X_PLUS[k] ? FACTOR_ONE + cx : FACTOR_ONE - cx;
      fy     = Y_PLUS[k] ? FACTOR_ONE + cy : FACTOR_ONE - cy;
      fz     = Z_PLUS[k] ? FACTOR_ONE + cz : FACTOR_ONE - cz;
      // Q6.42 product read as Q3.45 folds in the divide by eight
      weight = fx * fy * fz;
      term   = weight * corner[k];
      acc    = acc + term;
    end
    rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
    if (rounded > VAL_MAX) begin
      r.value     = VAL_MAX[VALUE_WIDTH-1:0];
      r.saturated = 1'b1;
    end else if (rounded < VAL_MIN) begin
      r.value     = VAL_MIN[VALUE_WIDTH-1:0];
      r.saturated = 1'b1;
    end else begin
      r.value     = rounded[VALUE_WIDTH-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Result transaction first: with pipeline latency it never matches a
  // point accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected (value %0d sat %0b)",
                                 result_count, out_mon_i.interp_value, out_mon_i.saturated));
        end else begin
          oldest = expected_results.pop_front();
          if (out_mon_i.interp_value !== oldest.value) begin
            note_failure($sformatf("result %0d interp_value expected %0d got %0d",
                                   result_count, oldest.value, out_mon_i.interp_value));
          end
          if (out_mon_i.saturated !== oldest.saturated) begin
            note_failure($sformatf("result %0d saturated expected %0b got %0b",
                                   result_count, oldest.saturated, out_mon_i.saturated));
          end
          if (oldest.saturated) clip_count++;
        end
        result_count++;
      end

      // Point transaction: predict its result
      if (in_mon_i.valid && in_mon_i.ready) begin
        corner_buf[0] = in_mon_i.corner_value_0;
        corner_buf[1] = in_mon_i.corner_value_1;
        corner_buf[2] = in_mon_i.corner_value_2;
        corner_buf[3] = in_mon_i.corner_value_3;
        corner_buf[4] = in_mon_i.corner_value_4;
        corner_buf[5] = in_mon_i.corner_value_5;
        corner_buf[6] = in_mon_i.corner_value_6;
        corner_buf[7] = in_mon_i.corner_value_7;
        expected_results.push_back(trilinear_sum(in_mon_i.coord_x, in_mon_i.coord_y,
                                                 in_mon_i.coord_z, corner_buf));
      end
      pending_count = expected_results.size();
    end
  end

endmodule

[dv/hex8_trilinear_interpolation_test.sv]
// Testbench top for the hex8 interpolator: clock, reset, stimulus and verdict.
module hex8_trilinear_interpolation_test
  import hti_pkg::*;
();

  localparam int unsigned VW           = VALUE_WIDTH_DEF;
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned PHASE_POINTS = 350;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LIMIT_CYCLES = 400000;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic        clk;
  logic        rst_n;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned points_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned clipped;

  hti_in_if  #(.VALUE_WIDTH(VW)) point_if ();
  hti_out_if #(.VALUE_WIDTH(VW)) result_if ();

  hex8_trilinear_interpolation #(
    .VALUE_WIDTH (VW)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (point_if),
    .out_o  (result_if)
  );

  hex8_trilinear_interpolation_checker #(
    .VALUE_WIDTH (VW)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (point_if),
    .out_mon_i    (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Hard stop
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL hex8_trilinear_interpolation");
    $finish;
  end

  // Result side back-pressure
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One point transaction, preceded by a random idle gap
  task automatic send_point(
    input logic signed [15:0]    x,
    input logic signed [15:0]    y,
    input logic signed [15:0]    z,
    input logic signed [VW-1:0]  v [8]
  );
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_if.valid          <= 1'b1;
    point_if.coord_x        <= x;
    point_if.coord_y        <= y;
    point_if.coord_z        <= z;
    point_if.corner_value_0 <= v[0];
    point_if.corner_value_1 <= v[1];
    point_if.corner_value_2 <= v[2];
    point_if.corner_value_3 <= v[3];
    point_if.corner_value_4 <= v[4];
    point_if.corner_value_5 <= v[5];
    point_if.corner_value_6 <= v[6];
    point_if.corner_value_7 <= v[7];
    // ready is stable mid-cycle, so look there and take the next edge
    @(negedge clk);
    while (!point_if.ready) @(negedge clk);
    @(posedge clk);
    points_sent++;
  endtask

  // Hold the sender until every outstanding result is back
  task automatic drain_results();
    point_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_coord();
    int c;
    case ($urandom_range(9))
      0:       c = -16384;
      1:       c = 16384;
      2:       c = 0;
      3:       c = int'($urandom_range(65535)) - 32768;  // extrapolating
      default: c = int'($urandom_range(32768)) - 16384;
    endcase
    return 16'(c);
  endfunction

  function automatic logic signed [VW-1:0] random_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(7))
      0:       v = VMAX;
      1:       v = VMIN;
      2:       v = VW'(int'($urandom_range(1 << 20)) - (1 << 19));
      default: v = VW'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  task automatic send_random_points(input int unsigned count);
    logic signed [VW-1:0] v [8];
    logic signed [VW-1:0] common;
    bit                   flat;
    int                   k;
    repeat (count) begin
      // some elements carry one uniform value: the sum must return it
      flat   = ($urandom_range(9) == 0);
      common = random_value();
      for (k = 0; k < 8; k++) v[k] = flat ? common : random_value();
      send_point(random_coord(), random_coord(), random_coord(), v);
    end
  endtask

  // Directed points: corners, center, rounding ties, extrapolation, extremes
  task automatic send_directed_points();
    logic signed [VW-1:0] v [8];
    logic signed [15:0]   one;
    int                   j, k;
    one = 16'sd16384;
    for (k = 0; k < 8; k++) begin
      for (j = 0; j < 8; j++) v[j] = VW'(((j % 2) ? -1 : 1) * (j + 1) * 70001);
      v[k] = (k % 2) ? VMIN : VMAX;
      send_point(SIGN_X[k] ? one : -one, SIGN_Y[k] ? one : -one,
                 SIGN_Z[k] ? one : -one, v);
    end
    // center of the element with extreme values
    for (j = 0; j < 8; j++) v[j] = VMAX;
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    for (j = 0; j < 8; j++) v[j] = VMIN;
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    for (j = 0; j < 8; j++) v[j] = (j % 2) ? VMIN : VMAX;
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    // ties at one half round toward plus infinity
    for (j = 0; j < 8; j++) v[j] = '0;
    v[0] = VW'(4);
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    v[0] = -VW'(4);
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    v[0] = -VW'(12);
    send_point(16'sd0, 16'sd0, 16'sd0, v);
    // far outside the element: extrapolated weights clip high and low
    for (j = 0; j < 8; j++) v[j] = '0;
    v[6] = VMAX;
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, v);
    v[6] = VMIN;
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, v);
    for (j = 0; j < 8; j++) v[j] = (j == 0) ? VMAX : VMIN;
    send_point(16'sh8000, 16'sh8000, 16'sh8000, v);
    for (j = 0; j < 8; j++) v[j] = random_value();
    send_point(16'sh8000, 16'sh7fff, 16'sd0, v);
    // one LSB off center
    for (j = 0; j < 8; j++) v[j] = (j < 4) ? VMAX : VMIN;
    send_point(16'sd1, -16'sd1, 16'sd1, v);
    send_point(-16'sd1, 16'sd1, -16'sd1, v);
  endtask

  // Stimulus and verdict
  initial begin
    rst_n                   = 1'b0;
    tx_idle_pct             = 10;
    rx_idle_pct             = 86;
    points_sent             = 0;
    point_if.valid          = 1'b0;
    point_if.coord_x        = '0;
    point_if.coord_y        = '0;
    point_if.coord_z        = '0;
    point_if.corner_value_0 = '0;
    point_if.corner_value_1 = '0;
    point_if.corner_value_2 = '0;
    point_if.corner_value_3 = '0;
    point_if.corner_value_4 = '0;
    point_if.corner_value_5 = '0;
    point_if.corner_value_6 = '0;
    point_if.corner_value_7 = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed_points();
    drain_results();

    // slow receiver
    send_random_points(PHASE_POINTS);
    drain_results();

    // slow sender
    tx_idle_pct = 86;
    rx_idle_pct = 10;
    send_random_points(PHASE_POINTS);
    drain_results();

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_points(PHASE_POINTS);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d points, checked %0d results (%0d clipped),", points_sent, checked,
             clipped);
    $display("over slow-receiver, slow-sender and full-rate pacing, with extrapolated points.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS hex8_trilinear_interpolation");
    end else begin
      $display("FAIL hex8_trilinear_interpolation");
    end
    $finish;
  end

endmodule
